>>> hdl/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared types and constants for the page framebuffer scan-out block.
// ----------------------------------------------------------------------------
`default_nettype none

package pfb_pkg;

  // Opcodes of an input transaction
  localparam logic [1:0] OP_DRAW = 2'd0;
  localparam logic [1:0] OP_FILL = 2'd1;
  localparam logic [1:0] OP_EMIT = 2'd2;

  // Command bytes sent ahead of each page
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LO    = 8'h00;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;
  localparam int unsigned CMD_SLOTS    = 3;

  localparam logic [7:0] FILL_ONES  = 8'hFF;
  localparam logic [7:0] FILL_ZEROS = 8'h00;

  localparam int unsigned DEF_FRAME_WIDTH  = 128;
  localparam int unsigned DEF_FRAME_HEIGHT = 64;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic       color;
  } pfb_in_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       is_data;
    logic       frame_done;
  } pfb_out_t;

endpackage

`default_nettype wire

>>> hdl/page_framebuffer_scanout.sv
// ----------------------------------------------------------------------------
// page_framebuffer_scanout
// Monochrome page-organized frame store with byte-serial scan-out.
// ----------------------------------------------------------------------------
// A pixel draw reads the store byte in the accept cycle and writes the
// modified byte back in the next, then the next transaction is taken. A draw
// outside the frame and the unused opcode leave the sequencer idle. An emit
// reads the store in the accept cycle (for a data slot), then loads the output
// register, and waits only while the previous result is still held on the output.
// A fill walks the single write port of the store, one byte a cycle, over
// all PAGES*FRAME_WIDTH bytes, where PAGES = ceil(FRAME_HEIGHT/8). After reset
// the same walk clears the store, and in_ready stays low until it ends.
// ----------------------------------------------------------------------------
`default_nettype none

module page_framebuffer_scanout #(
  parameter int unsigned FRAME_WIDTH  = pfb_pkg::DEF_FRAME_WIDTH,
  parameter int unsigned FRAME_HEIGHT = pfb_pkg::DEF_FRAME_HEIGHT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pfb_pkg::pfb_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pfb_pkg::pfb_out_t     out_data
);

  import pfb_pkg::*;

  localparam int unsigned PAGES    = (FRAME_HEIGHT + 7) / 8;
  localparam int unsigned DEPTH    = PAGES * FRAME_WIDTH;
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned PW       = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned POSW     = $clog2(FRAME_WIDTH + CMD_SLOTS);
  localparam int unsigned POS_LAST = FRAME_WIDTH + CMD_SLOTS - 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DRAW  = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;
  localparam logic [1:0] S_SWEEP = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic [AW-1:0]   sweep_cnt_r, sweep_cnt_nxt;
  logic [7:0]      fill_val_r, fill_val_nxt;
  logic [PW-1:0]   scan_page_r, scan_page_nxt;
  logic [POSW-1:0] scan_pos_r, scan_pos_nxt;
  logic [AW-1:0]   draw_addr_r;
  logic [2:0]      draw_bit_r;
  logic            draw_color_r;
  logic [7:0]      emit_cmd_r;
  logic            emit_data_r;
  logic            emit_done_r;
  logic            out_valid_r, out_valid_nxt;
  pfb_out_t        out_r;

  logic            accept;
  logic            draw_hit;
  logic [AW-1:0]   draw_addr;
  logic [AW-1:0]   scan_addr;
  logic [7:0]      scan_cmd;
  logic            scan_is_data;
  logic            scan_wrap;
  logic            page_wrap;
  logic [7:0]      draw_mask;
  logic [7:0]      rd_data;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [7:0]      wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  // Draw address: page row times width plus column
  assign draw_hit  = (in_data.pos_x < 8'(FRAME_WIDTH)) && (in_data.pos_y < 8'(FRAME_HEIGHT));
  assign draw_addr = AW'(AW'(in_data.pos_y[7:3]) * AW'(FRAME_WIDTH)) + AW'(in_data.pos_x);

  // Scan-out slot decode
  assign scan_is_data = (scan_pos_r >= POSW'(CMD_SLOTS));
  assign scan_addr    = AW'(AW'(scan_page_r) * AW'(FRAME_WIDTH))
                      + AW'(scan_pos_r - POSW'(CMD_SLOTS));
  assign scan_wrap    = (scan_pos_r == POSW'(POS_LAST));
  assign page_wrap    = (scan_page_r == PW'(PAGES - 1));

  always_comb begin
    unique case (scan_pos_r)
      POSW'(0): scan_cmd = CMD_PAGE_BASE + 8'(scan_page_r);
      POSW'(1): scan_cmd = CMD_COL_LO;
      default:  scan_cmd = CMD_COL_HI;
    endcase
  end

  assign draw_mask = 8'(1) << draw_bit_r;

  // Store port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = draw_addr_r;
    wr_data = draw_color_r ? (rd_data | draw_mask) : (rd_data & ~draw_mask);
    if (state_r == S_SWEEP) begin
      wr_en   = 1'b1;
      wr_addr = sweep_cnt_r;
      wr_data = fill_val_r;
    end else if (state_r == S_DRAW) begin
      wr_en   = 1'b1;
    end
    rd_en   = 1'b0;
    rd_addr = draw_addr;
    if (accept && (in_data.opcode == OP_DRAW) && draw_hit) begin
      rd_en = 1'b1;
    end else if (accept && (in_data.opcode == OP_EMIT)) begin
      rd_en   = scan_is_data;
      rd_addr = scan_addr;
    end
  end

  pfb_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    sweep_cnt_nxt = sweep_cnt_r;
    fill_val_nxt  = fill_val_r;
    scan_page_nxt = scan_page_r;
    scan_pos_nxt  = scan_pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.opcode)
            OP_DRAW: begin
              if (draw_hit) begin
                state_nxt = S_DRAW;
              end
            end
            OP_FILL: begin
              state_nxt     = S_SWEEP;
              sweep_cnt_nxt = '0;
              fill_val_nxt  = in_data.color ? FILL_ONES : FILL_ZEROS;
            end
            OP_EMIT: begin
              state_nxt = S_EMIT;
              if (scan_wrap) begin
                scan_pos_nxt  = '0;
                scan_page_nxt = page_wrap ? '0 : scan_page_r + PW'(1);
              end else begin
                scan_pos_nxt  = scan_pos_r + POSW'(1);
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_DRAW: begin
        state_nxt = S_IDLE;
      end
      S_EMIT: begin
        // Hold the result until the output register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (sweep_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          sweep_cnt_nxt = sweep_cnt_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_cnt_r <= '0;
      fill_val_r  <= FILL_ZEROS;
      scan_page_r <= '0;
      scan_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      fill_val_r  <= fill_val_nxt;
      scan_page_r <= scan_page_nxt;
      scan_pos_r  <= scan_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      draw_addr_r  <= draw_addr;
      draw_bit_r   <= in_data.pos_y[2:0];
      draw_color_r <= in_data.color;
      emit_cmd_r   <= scan_cmd;
      emit_data_r  <= scan_is_data;
      emit_done_r  <= scan_wrap && page_wrap;
    end
    if ((state_r == S_EMIT) && out_free) begin
      out_r.bus_byte   <= emit_data_r ? rd_data : emit_cmd_r;
      out_r.is_data    <= emit_data_r;
      out_r.frame_done <= emit_done_r;
    end
  end

  // Checks
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> !in_ready)
    else $error("input taken during store sweep");

  a_emit_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.opcode == OP_EMIT)) |=> (state_r == S_EMIT))
    else $error("emit transaction lost");

  a_done_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.frame_done) |-> out_r.is_data)
    else $error("frame end flagged on a command byte");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_pos_r <= POSW'(POS_LAST)) && (scan_page_r <= PW'(PAGES - 1)))
    else $error("scan position out of range");

endmodule

`default_nettype wire

>>> hdl/pfb_store.sv
// ----------------------------------------------------------------------------
// pfb_store
// Frame store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data_r
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
